FILE: design/card_uid_allow_table_macros.svh
// ---------------------------------------------------------------------------
// card_uid_allow_table_macros.svh
// Assertion macros shared by the allow-table checker.
// ---------------------------------------------------------------------------
`ifndef CARD_UID_ALLOW_TABLE_MACROS_SVH
`define CARD_UID_ALLOW_TABLE_MACROS_SVH

// Checked only outside reset.
`define CUAT_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Checked at every edge, reset included.
`define CUAT_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) else $error(msg);

`endif

FILE: design/cuat_pkg.sv
// ---------------------------------------------------------------------------
// cuat_pkg
// Shared types and codes for the card identifier allow table.
// ---------------------------------------------------------------------------
`default_nettype none

package cuat_pkg;

    localparam int UID_W   = 32;
    localparam int ECNT_W  = 5;

    localparam logic MODE_LOOKUP = 1'b0;
    localparam logic MODE_ENROLL = 1'b1;

    typedef enum logic [2:0] {
        ST_ADDED      = 3'd0,
        ST_FULL       = 3'd1,
        ST_DUPLICATE  = 3'd2,
        ST_REGISTERED = 3'd3,
        ST_UNKNOWN    = 3'd4
    } status_t;

    typedef struct packed {
        status_t             status;
        logic [UID_W-1:0]    matched_uid;
        logic [ECNT_W-1:0]   entry_count;
    } result_t;

endpackage

`default_nettype wire

FILE: design/cuat_uid_mem.sv
// ---------------------------------------------------------------------------
// cuat_uid_mem
// Identifier store: one write port, one registered read port.
// ---------------------------------------------------------------------------
`default_nettype none

module cuat_uid_mem
    import cuat_pkg::*;
#(
    parameter int DEPTH = 16,
    parameter int IDX_W = 4
) (
    input  wire logic              aclk,
    input  wire logic              wr_en,
    input  wire logic [IDX_W-1:0]  wr_addr,
    input  wire logic [UID_W-1:0]  wr_data,
    input  wire logic              rd_en,
    input  wire logic [IDX_W-1:0]  rd_addr,
    output logic      [UID_W-1:0]  rd_data
);

    logic [UID_W-1:0] mem_array [DEPTH];
    logic [UID_W-1:0] rd_data_reg;

    // No reset: entries are only read below the fill count.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_array[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_array[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

FILE: design/cuat_ctrl.sv
// ---------------------------------------------------------------------------
// cuat_ctrl
// Scan sequencer: walks stored entries through one shared comparator.
// ---------------------------------------------------------------------------
`default_nettype none

module cuat_ctrl
    import cuat_pkg::*;
#(
    parameter int CAPACITY = 16,
    parameter int IDX_W    = 4,
    parameter int CNT_W    = 5
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire logic              in_mode,
    input  wire logic [UID_W-1:0]  in_uid,
    output logic                   res_valid,
    input  wire logic              res_ready,
    output result_t                res,
    output logic                   mem_wr_en,
    output logic      [IDX_W-1:0]  mem_wr_addr,
    output logic      [UID_W-1:0]  mem_wr_data,
    output logic                   mem_rd_en,
    output logic      [IDX_W-1:0]  mem_rd_addr,
    input  wire logic [UID_W-1:0]  mem_rd_data
);

    localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_EMIT
    } state_t;

    state_t            state_reg, state_next;
    logic              enroll_reg, enroll_next;
    logic [UID_W-1:0]  uid_reg, uid_next;
    logic [CNT_W-1:0]  scan_idx_reg, scan_idx_next;
    logic              cmp_vld_reg, cmp_vld_next;
    status_t           status_reg, status_next;
    logic [CNT_W-1:0]  count_reg, count_next;

    logic              issue;
    logic              hit;
    logic [CNT_W-1:0]  count_plus;
    logic [CNT_W-1:0]  count_out;
    logic [CNT_W+ECNT_W-1:0] count_ext;

    assign issue      = (scan_idx_reg != count_reg);
    assign hit        = cmp_vld_reg && (mem_rd_data == uid_reg);
    assign count_plus = count_reg + CNT_W'(1);

    always_comb begin
        state_next    = state_reg;
        enroll_next   = enroll_reg;
        uid_next      = uid_reg;
        scan_idx_next = scan_idx_reg;
        cmp_vld_next  = cmp_vld_reg;
        status_next   = status_reg;
        count_next    = count_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (in_valid) begin
                    uid_next      = in_uid;
                    enroll_next   = (in_mode == MODE_ENROLL);
                    scan_idx_next = '0;
                    cmp_vld_next  = 1'b0;
                    if ((in_mode == MODE_ENROLL) && (count_reg == CAP_CNT)) begin
                        status_next = ST_FULL;
                        state_next  = S_EMIT;
                    end else begin
                        state_next  = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                if (hit) begin
                    status_next = enroll_reg ? ST_DUPLICATE : ST_REGISTERED;
                    state_next  = S_EMIT;
                end else if (!issue && !cmp_vld_reg) begin
                    status_next = enroll_reg ? ST_ADDED : ST_UNKNOWN;
                    state_next  = S_EMIT;
                end else begin
                    scan_idx_next = scan_idx_reg + CNT_W'(issue);
                    cmp_vld_next  = issue;
                end
            end
            S_EMIT: begin
                if (res_ready) begin
                    if (status_reg == ST_ADDED) begin
                        count_next = count_plus;
                    end
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        enroll_reg   <= enroll_next;
        uid_reg      <= uid_next;
        scan_idx_reg <= scan_idx_next;
        status_reg   <= status_next;
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            cmp_vld_reg <= 1'b0;
            count_reg   <= '0;
        end else begin
            state_reg   <= state_next;
            cmp_vld_reg <= cmp_vld_next;
            count_reg   <= count_next;
        end
    end

    assign in_ready = (state_reg == S_IDLE);

    // read one entry per cycle; compare lands in the next cycle
    assign mem_rd_en   = (state_reg == S_SCAN) && issue;
    assign mem_rd_addr = scan_idx_reg[IDX_W-1:0];

    // append happens when the result leaves
    assign mem_wr_en   = (state_reg == S_EMIT) && res_ready && (status_reg == ST_ADDED);
    assign mem_wr_addr = count_reg[IDX_W-1:0];
    assign mem_wr_data = uid_reg;

    assign count_out = (status_reg == ST_ADDED) ? count_plus : count_reg;
    assign count_ext = {{ECNT_W{1'b0}}, count_out};

    assign res_valid       = (state_reg == S_EMIT);
    assign res.status      = status_reg;
    assign res.matched_uid = (status_reg == ST_REGISTERED) ? uid_reg : '0;
    assign res.entry_count = count_ext[ECNT_W-1:0];

endmodule

`default_nettype wire

FILE: design/card_uid_allow_table.sv
// Operation: a lookup or enroll scans the n stored entries at one per cycle;
//   the scan stops early on a hit, and a full-table enroll skips it and goes
//   straight to the result, which then passes to the output register.
// Flow: a new item is accepted only once the sequencer has handed off the last
//   result; the scan loop over the identifier store's single read port sets the pace.
// Reset: aresetn low clears the fill count, sequencer and output valid.
// ---------------------------------------------------------------------------
// card_uid_allow_table
// Allow-list of 32-bit card identifiers with enroll and lookup requests.
// ---------------------------------------------------------------------------
`default_nettype none

module card_uid_allow_table
    import cuat_pkg::*;
#(
    parameter int CAPACITY = 16
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    // input item
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [31:0]  s_tdata,   // [31:0] card_uid
    input  wire logic [0:0]   s_tuser,   // [0] mode (0 lookup, 1 enroll)
    // result item
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic      [39:0]  m_tdata,   // [31:0] matched_uid, [36:32] entry_count, zero pad
    output logic      [2:0]   m_tuser    // [2:0] status
);

    // Index needs at least one bit even for a single entry table.
    localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    // Count must hold CAPACITY itself.
    localparam int CNT_W = $clog2(CAPACITY + 1);

    logic              res_valid;
    logic              res_ready;
    result_t           res;

    logic              mem_wr_en;
    logic [IDX_W-1:0]  mem_wr_addr;
    logic [UID_W-1:0]  mem_wr_data;
    logic              mem_rd_en;
    logic [IDX_W-1:0]  mem_rd_addr;
    logic [UID_W-1:0]  mem_rd_data;

    logic              m_tvalid_reg;
    result_t           out_reg;

    // Sequencer plus shared comparator; holds the fill count.
    cuat_ctrl #(
        .CAPACITY (CAPACITY),
        .IDX_W    (IDX_W),
        .CNT_W    (CNT_W)
    ) u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .in_mode     (s_tuser[0]),
        .in_uid      (s_tdata),
        .res_valid   (res_valid),
        .res_ready   (res_ready),
        .res         (res),
        .mem_wr_en   (mem_wr_en),
        .mem_wr_addr (mem_wr_addr),
        .mem_wr_data (mem_wr_data),
        .mem_rd_en   (mem_rd_en),
        .mem_rd_addr (mem_rd_addr),
        .mem_rd_data (mem_rd_data)
    );

    // Identifier store, read one entry per cycle during a scan.
    cuat_uid_mem #(
        .DEPTH (CAPACITY),
        .IDX_W (IDX_W)
    ) u_mem (
        .aclk    (aclk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

    // Output register: sequencer hands off as soon as the slot is free,
    // so it can go back to idle while the downstream side stalls.
    assign res_ready = !m_tvalid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (res_valid && res_ready) begin
            out_reg <= res;
        end
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (res_ready) begin
            m_tvalid_reg <= res_valid;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = out_reg.status;
    assign m_tdata  = {3'b000, out_reg.entry_count, out_reg.matched_uid};

endmodule

`default_nettype wire

FILE: design/cuat_checker.sv
// ---------------------------------------------------------------------------
// cuat_checker
// Port-level checks for the card identifier allow table.
// ---------------------------------------------------------------------------
`default_nettype none

`include "card_uid_allow_table_macros.svh"

module cuat_checker
    import cuat_pkg::*;
#(
    parameter int CAPACITY = 16
) (
    input wire logic         aclk,
    input wire logic         aresetn,
    input wire logic         s_tvalid,
    input wire logic         s_tready,
    input wire logic         m_tvalid,
    input wire logic         m_tready,
    input wire logic [39:0]  m_tdata,
    input wire logic [2:0]   m_tuser
);

    localparam logic [ECNT_W-1:0] FULL_CNT = ECNT_W'(CAPACITY % 32);

    `CUAT_ASSERT_ALWAYS(a_reset_clears_valid, !aresetn |=> !m_tvalid, "valid after reset")

    `CUAT_ASSERT(a_out_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser), "result changed while stalled")

    `CUAT_ASSERT(a_busy_after_accept, s_tvalid && s_tready |=> !s_tready, "accepted two items back to back")

    `CUAT_ASSERT(a_echo_only_on_match, m_tvalid && (m_tuser != ST_REGISTERED) |-> (m_tdata[31:0] == 32'd0), "identifier echoed without a match")

    `CUAT_ASSERT(a_full_count, m_tvalid && (m_tuser == ST_FULL) |-> (m_tdata[36:32] == FULL_CNT), "table full reported below capacity")

endmodule

bind card_uid_allow_table cuat_checker #(.CAPACITY(CAPACITY)) u_cuat_checker (.*);

`default_nettype wire
